@@ src/teed_pkg.sv @@
`default_nettype none

package teed_pkg;

  // Counter and length widths
  localparam int CNT_W   = 17;
  localparam int NUM_CNT = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Buffer size in bytes; words reaching beyond it are not counted
  localparam int MAX_BYTES = 65536;
  // Wide enough to hold MAX_BYTES plus one word at the top of its range
  localparam int LEN_W = 21;

  // Below this byte count the line ending uses the count-difference rule
  localparam logic [CNT_W-1:0] SMALL_LEN = CNT_W'(32'h400);

  // Stream widths
  localparam int WORD_W    = 32;
  localparam int NBYTES_W  = 3;
  localparam int S_TDATA_W = 40;
  localparam int ENC_W     = 3;
  localparam int EOL_W     = 2;
  localparam int M_TDATA_W = 8;

  // Counter slots
  localparam int IDX_LF32LE = 0;
  localparam int IDX_CR32LE = 1;
  localparam int IDX_LF32BE = 2;
  localparam int IDX_CR32BE = 3;
  localparam int IDX_LF16LE = 4;
  localparam int IDX_CR16LE = 5;
  localparam int IDX_LF16BE = 6;
  localparam int IDX_CR16BE = 7;
  localparam int IDX_LF8    = 8;
  localparam int IDX_CR8    = 9;

  // Configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam int CFG_W     = 3;
  localparam logic [REG_IDX_W-1:0] REG_FILE_BOM  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_MOD4 = 1'b1;

  // Byte order mark codes
  localparam logic [2:0] BOM_NONE    = 3'd0;
  localparam logic [2:0] BOM_UTF8    = 3'd1;
  localparam logic [2:0] BOM_UTF16LE = 3'd2;
  localparam logic [2:0] BOM_UTF16BE = 3'd3;
  localparam logic [2:0] BOM_UTF32LE = 3'd4;
  localparam logic [2:0] BOM_UTF32BE = 3'd5;

  // Encoding codes
  localparam logic [ENC_W-1:0] ENC_8BIT    = 3'd0;
  localparam logic [ENC_W-1:0] ENC_UTF32LE = 3'd1;
  localparam logic [ENC_W-1:0] ENC_UTF16LE = 3'd2;
  localparam logic [ENC_W-1:0] ENC_UTF32BE = 3'd3;
  localparam logic [ENC_W-1:0] ENC_UTF16BE = 3'd4;

  // Line ending codes
  localparam logic [EOL_W-1:0] EOL_NONE = 2'd0;
  localparam logic [EOL_W-1:0] EOL_LF   = 2'd1;
  localparam logic [EOL_W-1:0] EOL_CR   = 2'd2;
  localparam logic [EOL_W-1:0] EOL_CRLF = 2'd3;

  typedef logic [CNT_W-1:0] cnt_t;

  // Counter values and byte length after the final word of a chunk
  typedef struct packed {
    cnt_t [NUM_CNT-1:0] cnt;
    cnt_t               len;
  } snap_t;

endpackage

`default_nettype wire

@@ src/teed_counter.sv @@
`default_nettype none

module teed_counter (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [teed_pkg::WORD_W-1:0]   word_i,
  input  wire logic [teed_pkg::NBYTES_W-1:0] nbytes_i,
  input  wire logic                     last_i,
  output logic                          snap_valid_o,
  input  wire logic                     snap_ready_i,
  output teed_pkg::snap_t               snap_o
);
  import teed_pkg::*;

  function automatic cnt_t sat_add(cnt_t a, logic [2:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(b);
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  logic                in_v_q;
  logic [WORD_W-1:0]   word_q;
  logic [NBYTES_W-1:0] nb_q;
  logic                last_q;
  cnt_t                cnt_q [NUM_CNT];
  cnt_t                len_q;

  cnt_t                cnt_new [NUM_CNT];
  cnt_t                len_new;
  logic [2:0]          inc [NUM_CNT];
  logic [NBYTES_W-1:0] nb_eff;
  logic [WORD_W-1:0]   pw;
  logic [15:0]         lo, hi;
  logic                count_en;
  logic                in_move;

  // Pad missing upper bytes with spaces and find the LF/CR matches
  always_comb begin
    nb_eff = (nb_q > 3'd4) ? 3'd4 : nb_q;
    for (int k = 0; k < 4; k++) begin
      pw[8*k +: 8] = (3'(k) < nb_eff) ? word_q[8*k +: 8] : 8'h20;
    end
    lo = pw[15:0];
    hi = pw[31:16];
    inc[IDX_LF32LE] = 3'(pw == 32'h0000000A);
    inc[IDX_CR32LE] = 3'(pw == 32'h0000000D);
    inc[IDX_LF32BE] = 3'(pw == 32'h0A000000);
    inc[IDX_CR32BE] = 3'(pw == 32'h0D000000);
    inc[IDX_LF16LE] = 3'(lo == 16'h000A) + 3'(hi == 16'h000A);
    inc[IDX_CR16LE] = 3'(lo == 16'h000D) + 3'(hi == 16'h000D);
    inc[IDX_LF16BE] = 3'(lo == 16'h0A00) + 3'(hi == 16'h0A00);
    inc[IDX_CR16BE] = 3'(lo == 16'h0D00) + 3'(hi == 16'h0D00);
    inc[IDX_LF8] = 3'(pw[7:0] == 8'h0A) + 3'(pw[15:8] == 8'h0A)
                 + 3'(pw[23:16] == 8'h0A) + 3'(pw[31:24] == 8'h0A);
    inc[IDX_CR8] = 3'(pw[7:0] == 8'h0D) + 3'(pw[15:8] == 8'h0D)
                 + 3'(pw[23:16] == 8'h0D) + 3'(pw[31:24] == 8'h0D);

    count_en = (nb_q != '0) &&
               ((LEN_W'(len_q) + LEN_W'(4)) <= LEN_W'(MAX_BYTES));

    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_new[i] = count_en ? sat_add(cnt_q[i], inc[i]) : cnt_q[i];
      snap_o.cnt[i] = cnt_new[i];
    end
    len_new = count_en ? sat_add(len_q, 3'd4) : len_q;
    snap_o.len = len_new;
  end

  // A plain word always retires; a last word waits for the decision stage
  assign snap_valid_o = in_v_q && last_q;
  assign in_move      = in_v_q && (!last_q || snap_ready_i);
  assign in_ready_o   = !in_v_q || in_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      len_q  <= '0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (in_move) begin
        // Clear everything once the chunk has been handed over
        for (int i = 0; i < NUM_CNT; i++) begin
          cnt_q[i] <= last_q ? '0 : cnt_new[i];
        end
        len_q <= last_q ? '0 : len_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_i;
      nb_q   <= nbytes_i;
      last_q <= last_i;
    end
  end

endmodule

`default_nettype wire

@@ src/teed_decide.sv @@
`default_nettype none

module teed_decide (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        snap_valid_i,
  output logic                             snap_ready_o,
  input  wire teed_pkg::snap_t             snap_i,
  input  wire logic [2:0]                  file_bom_i,
  input  wire logic [1:0]                  size_mod4_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [teed_pkg::ENC_W-1:0]       enc_o,
  output logic [teed_pkg::EOL_W-1:0]       eol_o
);
  import teed_pkg::*;

  // part*100 > whole*80 reduced to part*5 > whole*4
  function automatic logic above80(cnt_t part, cnt_t whole);
    logic [CNT_W+2:0] p5;
    logic [CNT_W+2:0] w4;
    p5 = ((CNT_W+3)'(part) << 2) + (CNT_W+3)'(part);
    w4 = (CNT_W+3)'(whole) << 2;
    return (whole != '0) && (p5 > w4);
  endfunction

  function automatic logic [EOL_W-1:0] guess_eol(cnt_t lf, cnt_t cr, cnt_t len);
    logic [CNT_W:0]   lf_w, cr_w, mx, lf2, cr2;
    logic             near_lo, lf_hi, cr_hi;
    logic [EOL_W-1:0] r;
    lf_w    = {1'b0, lf};
    cr_w    = {1'b0, cr};
    mx      = (lf > cr) ? lf_w : cr_w;
    lf2     = {lf, 1'b0};
    cr2     = {cr, 1'b0};
    lf_hi   = lf2 > mx;
    cr_hi   = cr2 > mx;
    near_lo = (lf_w + (CNT_W+1)'(2)) >= cr_w;
    if (lf == '0 && cr == '0) begin
      r = EOL_NONE;
    end else if (lf == cr) begin
      r = EOL_CRLF;
    end else if (cr == '0) begin
      r = EOL_LF;
    end else if (lf == '0) begin
      r = EOL_CR;
    end else if (len < SMALL_LEN) begin
      if (near_lo && (lf_w <= cr_w + (CNT_W+1)'(2))) begin
        r = EOL_CRLF;
      end else begin
        r = near_lo ? EOL_LF : EOL_CR;
      end
    end else if (lf_hi && cr_hi) begin
      r = EOL_CRLF;
    end else begin
      r = lf_hi ? EOL_LF : EOL_CR;
    end
    return r;
  endfunction

  logic             snap_v_q;
  snap_t            snap_q;
  logic             out_ready;
  logic             al4, al2;
  logic             any_eol;
  logic [ENC_W-1:0] enc_d;
  logic [EOL_W-1:0] eol_d;
  cnt_t             lf, cr;

  assign out_ready    = !out_valid_o || out_ready_i;
  assign snap_ready_o = !snap_v_q || out_ready;

  always_comb begin
    al4     = size_mod4_i == 2'd0;
    al2     = !size_mod4_i[0];
    any_eol = (snap_q.cnt[IDX_LF8] != '0) || (snap_q.cnt[IDX_CR8] != '0);
    if (file_bom_i == BOM_UTF32LE ||
        (al4 && ((snap_q.cnt[IDX_LF32LE] == snap_q.cnt[IDX_LF16LE] &&
                  above80(snap_q.cnt[IDX_LF32LE], snap_q.cnt[IDX_LF8])) ||
                 (snap_q.cnt[IDX_CR32LE] == snap_q.cnt[IDX_CR16LE] &&
                  above80(snap_q.cnt[IDX_CR32LE], snap_q.cnt[IDX_CR8]))))) begin
      enc_d = ENC_UTF32LE;
      lf    = snap_q.cnt[IDX_LF32LE];
      cr    = snap_q.cnt[IDX_CR32LE];
    end else if (file_bom_i == BOM_UTF16LE ||
                 (al2 && (above80(snap_q.cnt[IDX_LF16LE], snap_q.cnt[IDX_LF8]) ||
                          above80(snap_q.cnt[IDX_CR16LE], snap_q.cnt[IDX_CR8])))) begin
      enc_d = ENC_UTF16LE;
      lf    = snap_q.cnt[IDX_LF16LE];
      cr    = snap_q.cnt[IDX_CR16LE];
    end else if (file_bom_i == BOM_UTF32BE ||
        (al4 && ((snap_q.cnt[IDX_LF32BE] == snap_q.cnt[IDX_LF16BE] &&
                  above80(snap_q.cnt[IDX_LF32BE], snap_q.cnt[IDX_LF8])) ||
                 (snap_q.cnt[IDX_CR32BE] == snap_q.cnt[IDX_CR16BE] &&
                  above80(snap_q.cnt[IDX_CR32BE], snap_q.cnt[IDX_CR8]))))) begin
      enc_d = ENC_UTF32BE;
      lf    = snap_q.cnt[IDX_LF32BE];
      cr    = snap_q.cnt[IDX_CR32BE];
    end else if (file_bom_i == BOM_UTF16BE ||
                 (al2 && (above80(snap_q.cnt[IDX_LF16BE], snap_q.cnt[IDX_LF8]) ||
                          above80(snap_q.cnt[IDX_CR16BE], snap_q.cnt[IDX_CR8])))) begin
      enc_d = ENC_UTF16BE;
      lf    = snap_q.cnt[IDX_LF16BE];
      cr    = snap_q.cnt[IDX_CR16BE];
    end else begin
      enc_d = ENC_8BIT;
      lf    = snap_q.cnt[IDX_LF8];
      cr    = snap_q.cnt[IDX_CR8];
    end
    eol_d = guess_eol(lf, cr, snap_q.len);
    // No LF or CR byte at all: report nothing, whatever the mark says
    if (!any_eol) begin
      enc_d = ENC_8BIT;
      eol_d = EOL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (snap_ready_o) begin
        snap_v_q <= snap_valid_i;
      end
      if (out_ready) begin
        out_valid_o <= snap_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      snap_q <= snap_i;
    end
    if (out_ready && snap_v_q) begin
      enc_o <= enc_d;
      eol_o <= eol_d;
    end
  end

endmodule

`default_nettype wire

@@ src/text_encoding_eol_detector_core.sv @@
// Text encoding and line-ending detector.
// Slave stream: one transaction per 32-bit word of the file's opening bytes,
// first byte in the low bits; tlast marks the final word of the chunk.
// Each non-empty word updates ten saturating LF/CR match counters and a
// byte count; words that would run past the buffer size are not counted.
// Master stream: one transaction per chunk, carrying the encoding guess and
// line-ending style decided from the counts once the final word is in.
// Configuration: write the byte order mark code and the file size modulo
// four through the write port while no chunk is in flight.
// Throughput: one word per cycle, back to back, no gaps at chunk borders,
// as long as no final word is held (see Stall). A final word reaches the
// master side via the input register, count snapshot and result register.
// Stall: plain words never wait on the master side; a final word holds in
// the input register only while both the snapshot and the result register
// are full, which happens when the receiver stalls across two chunks.
// Reset: counters, byte count and configuration return to zero, no result
// is pending, and the slave side is ready straight out of reset.
`default_nettype none

module text_encoding_eol_detector_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
  input  wire logic [teed_pkg::S_TDATA_W-1:0]        s_axis_tdata_i,
  input  wire logic                                  s_axis_tlast_i,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // [2:0] encoding_guess, [4:3] eol_style, [7:5] zero
  output logic [teed_pkg::M_TDATA_W-1:0]             m_axis_tdata_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [teed_pkg::REG_IDX_W-1:0]        cfg_addr_i,
  input  wire logic [teed_pkg::CFG_W-1:0]            cfg_wdata_i
);
  import teed_pkg::*;

  logic [2:0]       bom_q;
  logic [1:0]       size_mod4_q;
  logic             snap_valid;
  logic             snap_ready;
  snap_t            snap;
  logic [ENC_W-1:0] enc;
  logic [EOL_W-1:0] eol;

  // Configuration registers; writes take effect at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bom_q       <= BOM_NONE;
      size_mod4_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FILE_BOM:  bom_q       <= cfg_wdata_i;
        REG_SIZE_MOD4: size_mod4_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Input register and counters
  teed_counter u_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .word_i       (s_axis_tdata_i[WORD_W-1:0]),
    .nbytes_i     (s_axis_tdata_i[WORD_W +: NBYTES_W]),
    .last_i       (s_axis_tlast_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  // Snapshot register, decision logic and result register
  teed_decide u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .file_bom_i   (bom_q),
    .size_mod4_i  (size_mod4_q),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .enc_o        (enc),
    .eol_o        (eol)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W-ENC_W-EOL_W){1'b0}}, eol, enc};

`ifndef NO_ASSERTIONS
  // The byte count handed to the decision never runs past the buffer
  a_len_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid |-> (LEN_W'(snap.len) <= LEN_W'(MAX_BYTES)))
    else $error("byte count beyond buffer size");

  // With the result register empty the slave side never stalls
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // A snapshot taken while the result path is free reaches the master side
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_valid && snap_ready && (!m_axis_tvalid_o || m_axis_tready_i))
      |=> ##1 m_axis_tvalid_o)
    else $error("result missing after final word");
`endif

endmodule

`default_nettype wire

@@ tb/sv/text_encoding_eol_detector_core_test.sv @@
`timescale 1ns / 1ps

module text_encoding_eol_detector_core_test;
  import teed_pkg::*;

  // Stimulus shape
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 40;     // random words per phase, past the special chunks
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off that backs up the core
  localparam int SETTLE       = 8;      // cycles past the last result before touching config
  localparam int STALL_LIMIT  = 2000;   // cycles with no transaction before giving up
  localparam int NUM_ROWS     = 19;

  localparam logic [7:0] LF_BYTE  = 8'h0A;
  localparam logic [7:0] CR_BYTE  = 8'h0D;
  localparam logic [7:0] PAD_BYTE = 8'h20;

  // Code outside the defined BOM range; must not override anything
  localparam logic [2:0] BOM_UNKNOWN = 3'd7;

  typedef enum int {STYLE_8BIT, STYLE_16LE, STYLE_16BE, STYLE_32LE, STYLE_32BE, STYLE_NOISE}
    text_style_e;
  typedef enum int {MIX_LF, MIX_CR, MIX_BOTH, MIX_LF_HEAVY} eol_mix_e;

  typedef struct packed {
    logic [ENC_W-1:0] enc;
    logic [EOL_W-1:0] eol;
  } verdict_t;

  // One directed word; enc/eol only count when typed is set
  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [NBYTES_W-1:0] nbytes;
    logic                last;
    logic                typed;
    logic [ENC_W-1:0]    enc;
    logic [EOL_W-1:0]    eol;
  } row_t;

  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // single code units right after reset, results obvious from the counts
    '{32'h0000000A, 3'd4, 1'b1, 1'b1, ENC_UTF32LE, EOL_LF},
    '{32'h0D000000, 3'd4, 1'b1, 1'b1, ENC_UTF32BE, EOL_CR},
    '{32'h0000000D, 3'd4, 1'b1, 1'b1, ENC_UTF32LE, EOL_CR},
    // no LF or CR at all: nothing detected
    '{32'h41424344, 3'd4, 1'b1, 1'b1, ENC_8BIT, EOL_NONE},
    '{32'hFFFFFFFF, 3'd4, 1'b1, 1'b1, ENC_8BIT, EOL_NONE},
    '{32'h00000000, 3'd4, 1'b1, 1'b1, ENC_8BIT, EOL_NONE},
    // zero valid bytes: word dropped, last mark still decides
    '{32'h0000000A, 3'd0, 1'b1, 1'b1, ENC_8BIT, EOL_NONE},
    // valid bytes above four behave as four
    '{32'h000A000A, 3'd7, 1'b1, 1'b1, ENC_UTF16LE, EOL_LF},
    // the rest go through the predictor
    '{32'h0A000A00, 3'd4, 1'b1, 1'b0, ENC_8BIT, EOL_NONE},
    '{32'h0A0A0A0A, 3'd1, 1'b0, 1'b0, ENC_8BIT, EOL_NONE},  // short word, not last
    '{32'h0D0D0D0D, 3'd2, 1'b1, 1'b0, ENC_8BIT, EOL_NONE},  // counts close: CRLF
    '{32'h0D0D0D0D, 3'd4, 1'b0, 1'b0, ENC_8BIT, EOL_NONE},
    '{32'h0D20200A, 3'd4, 1'b1, 1'b0, ENC_8BIT, EOL_NONE},  // CR well ahead
    '{32'h41420D0A, 3'd4, 1'b1, 1'b0, ENC_8BIT, EOL_NONE},
    '{32'h0A0D0D0D, 3'd3, 1'b1, 1'b0, ENC_8BIT, EOL_NONE},
    '{32'hFFFFFFFF, 3'd5, 1'b0, 1'b0, ENC_8BIT, EOL_NONE},
    '{32'h0000000A, 3'd6, 1'b1, 1'b0, ENC_8BIT, EOL_NONE},
    '{32'h000D000A, 3'd4, 1'b1, 1'b0, ENC_8BIT, EOL_NONE},
    '{32'h0D000A00, 3'd4, 1'b1, 1'b0, ENC_8BIT, EOL_NONE}
  };

  // Per-phase configuration and idling
  localparam logic [2:0] PHASE_BOM [NUM_PHASES] = '{
    BOM_NONE, BOM_UTF16LE, BOM_UTF32BE, BOM_UTF8,
    BOM_UTF32LE, BOM_UTF16BE, BOM_UNKNOWN, BOM_NONE};
  localparam logic [1:0] PHASE_MOD [NUM_PHASES] = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 2'd2, 2'd0};
  localparam int PHASE_SEND_IDLE  [NUM_PHASES] = '{0, 73, 0, 12, 0, 73, 0, 12};
  localparam int PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 73, 12, 0, 0, 73, 12};

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                 s_tvalid  = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr  = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  wire                  s_axis_tready_o;
  wire                  m_axis_tvalid_o;
  wire [M_TDATA_W-1:0]  m_axis_tdata_o;

  text_encoding_eol_detector_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the detector: match counters, byte count and configuration
  int unsigned line_counts [NUM_CNT];
  int unsigned byte_count;
  logic [2:0]  bom_code;
  logic [1:0]  size_mod;

  // Verdicts predicted for chunks whose final word went in, oldest first
  verdict_t pending_verdicts [$];

  int          mismatch_count = 0;
  int          words_sent     = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;
  int          holds_requested = 0;
  int          holds_served    = 0;
  int          hold_left       = 0;
  int          quiet_cycles    = 0;
  verdict_t    seen_want;

  task automatic add_count(input int idx, input int unsigned amount);
    line_counts[idx] = (line_counts[idx] + amount > CNT_MAX) ? CNT_MAX
                                                              : line_counts[idx] + amount;
  endtask

  function automatic bit above80(input int unsigned part, input int unsigned whole);
    return whole != 0 && longint'(part) * 100 > longint'(whole) * 80;
  endfunction

  // Fold one accepted word into the counters
  task automatic tally_word(input logic [WORD_W-1:0] word, input logic [NBYTES_W-1:0] nbytes);
    logic [31:0] w;
    int          n;
    w = word;
    n = (nbytes > 3'd4) ? 4 : int'(nbytes);
    // drop empty words and words that would run past the buffer
    if (n != 0 && byte_count + 4 <= MAX_BYTES) begin
      for (int k = 0; k < 4; k++)
        if (k >= n) w[8*k +: 8] = PAD_BYTE;
      if (w == 32'h0000000A) add_count(IDX_LF32LE, 1);
      if (w == 32'h0000000D) add_count(IDX_CR32LE, 1);
      if (w == 32'h0A000000) add_count(IDX_LF32BE, 1);
      if (w == 32'h0D000000) add_count(IDX_CR32BE, 1);
      add_count(IDX_LF16LE, int'(w[15:0] == 16'h000A) + int'(w[31:16] == 16'h000A));
      add_count(IDX_CR16LE, int'(w[15:0] == 16'h000D) + int'(w[31:16] == 16'h000D));
      add_count(IDX_LF16BE, int'(w[15:0] == 16'h0A00) + int'(w[31:16] == 16'h0A00));
      add_count(IDX_CR16BE, int'(w[15:0] == 16'h0D00) + int'(w[31:16] == 16'h0D00));
      for (int k = 0; k < 4; k++) begin
        if (w[8*k +: 8] == LF_BYTE) add_count(IDX_LF8, 1);
        if (w[8*k +: 8] == CR_BYTE) add_count(IDX_CR8, 1);
      end
      byte_count = (byte_count + 4 > CNT_MAX) ? CNT_MAX : byte_count + 4;
    end
  endtask

  // Decide encoding and line ending for the chunk just closed, then clear the counts
  task automatic classify_chunk(output logic [ENC_W-1:0] enc, output logic [EOL_W-1:0] eol);
    bit          al4, al2, near_lo, lf_hi, cr_hi;
    int unsigned lf, cr, mx;
    int unsigned c [NUM_CNT];
    c   = line_counts;
    al4 = (size_mod == 2'd0);
    al2 = !size_mod[0];
    enc = ENC_8BIT;
    eol = EOL_NONE;
    if (c[IDX_LF8] != 0 || c[IDX_CR8] != 0) begin
      // fixed priority 32LE, 16LE, 32BE, 16BE, then 8-bit; each on its BOM or its ratio test
      if (bom_code == BOM_UTF32LE ||
          (al4 && ((c[IDX_LF32LE] == c[IDX_LF16LE] && above80(c[IDX_LF32LE], c[IDX_LF8])) ||
                   (c[IDX_CR32LE] == c[IDX_CR16LE] && above80(c[IDX_CR32LE], c[IDX_CR8]))))) begin
        enc = ENC_UTF32LE; lf = c[IDX_LF32LE]; cr = c[IDX_CR32LE];
      end else if (bom_code == BOM_UTF16LE ||
                   (al2 && (above80(c[IDX_LF16LE], c[IDX_LF8]) ||
                            above80(c[IDX_CR16LE], c[IDX_CR8])))) begin
        enc = ENC_UTF16LE; lf = c[IDX_LF16LE]; cr = c[IDX_CR16LE];
      end else if (bom_code == BOM_UTF32BE ||
          (al4 && ((c[IDX_LF32BE] == c[IDX_LF16BE] && above80(c[IDX_LF32BE], c[IDX_LF8])) ||
                   (c[IDX_CR32BE] == c[IDX_CR16BE] && above80(c[IDX_CR32BE], c[IDX_CR8]))))) begin
        enc = ENC_UTF32BE; lf = c[IDX_LF32BE]; cr = c[IDX_CR32BE];
      end else if (bom_code == BOM_UTF16BE ||
                   (al2 && (above80(c[IDX_LF16BE], c[IDX_LF8]) ||
                            above80(c[IDX_CR16BE], c[IDX_CR8])))) begin
        enc = ENC_UTF16BE; lf = c[IDX_LF16BE]; cr = c[IDX_CR16BE];
      end else begin
        enc = ENC_8BIT; lf = c[IDX_LF8]; cr = c[IDX_CR8];
      end
      // line ending from the chosen encoding's counts
      if (lf == 0 && cr == 0)  eol = EOL_NONE;
      else if (lf == cr)       eol = EOL_CRLF;
      else if (cr == 0)        eol = EOL_LF;
      else if (lf == 0)        eol = EOL_CR;
      else if (byte_count < SMALL_LEN) begin
        // short input: counts within two of each other mean CRLF
        near_lo = (lf + 2 >= cr);
        if (near_lo && lf <= cr + 2) eol = EOL_CRLF;
        else                         eol = near_lo ? EOL_LF : EOL_CR;
      end else begin
        // long input: a count is high when above half the larger one
        mx    = (lf > cr) ? lf : cr;
        lf_hi = (2 * lf > mx);
        cr_hi = (2 * cr > mx);
        if (lf_hi && cr_hi) eol = EOL_CRLF;
        else                eol = lf_hi ? EOL_LF : EOL_CR;
      end
    end
    foreach (line_counts[i]) line_counts[i] = 0;
    byte_count = 0;
  endtask

  // Offer one word; on acceptance advance the shadow and queue any verdict.
  // Called just after a rising edge, returns just after the accepting edge.
  task automatic send_word(input logic [WORD_W-1:0] word, input logic [NBYTES_W-1:0] nbytes,
                           input logic last, input bit typed,
                           input logic [ENC_W-1:0] t_enc, input logic [EOL_W-1:0] t_eol);
    logic [ENC_W-1:0] enc;
    logic [EOL_W-1:0] eol;
    verdict_t         v;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-WORD_W-NBYTES_W){1'b0}}, nbytes, word};
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_sent++;
    tally_word(word, nbytes);
    if (last) begin
      classify_chunk(enc, eol);
      // typed-in verdicts replace the prediction for the obvious cases
      if (typed) begin
        v.enc = t_enc;
        v.eol = t_eol;
      end else begin
        v.enc = enc;
        v.eol = eol;
      end
      pending_verdicts.push_back(v);
    end
  endtask

  // One code unit: mostly letters, sometimes a line break of the chosen mix
  function automatic logic [7:0] pick_unit(input eol_mix_e mix);
    if ($urandom_range(99) >= 25) return 8'h41 + 8'($urandom_range(25));
    case (mix)
      MIX_LF:       return LF_BYTE;
      MIX_CR:       return CR_BYTE;
      MIX_BOTH:     return $urandom_range(1) ? LF_BYTE : CR_BYTE;
      default:      return ($urandom_range(9) < 8) ? LF_BYTE : CR_BYTE;
    endcase
  endfunction

  function automatic logic [31:0] text_word(input text_style_e style, input eol_mix_e mix);
    case (style)
      STYLE_8BIT: return {pick_unit(mix), pick_unit(mix), pick_unit(mix), pick_unit(mix)};
      STYLE_16LE: return {8'h00, pick_unit(mix), 8'h00, pick_unit(mix)};
      STYLE_16BE: return {pick_unit(mix), 8'h00, pick_unit(mix), 8'h00};
      STYLE_32LE: return {24'h0, pick_unit(mix)};
      STYLE_32BE: return {pick_unit(mix), 24'h0};
      default:    return $urandom;
    endcase
  endfunction

  // Well-formed text of one encoding with some raw noise words mixed in
  task automatic send_chunk(input text_style_e style, input int len, input eol_mix_e mix);
    logic [31:0] word;
    logic [2:0]  nb;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) begin
        word = $urandom;
        nb   = 3'($urandom_range(7));
      end else begin
        word = text_word(style, mix);
        nb   = 3'd4;
        if (i == len - 1 && $urandom_range(2) == 0) nb = 3'($urandom_range(1, 4));
      end
      send_word(word, nb, i == len - 1, 1'b0, ENC_8BIT, EOL_NONE);
    end
  endtask

  // Drop valid, wait for every verdict, then let the pipeline drain
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [2:0] bom, input logic [1:0] smod);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_FILE_BOM;
    cfg_wdata <= bom;
    @(posedge clk_i);
    cfg_addr  <= REG_SIZE_MOD4;
    cfg_wdata <= {1'b0, smod};
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    bom_code = bom;
    size_mod = smod;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (holds_served != holds_requested) begin
      holds_served <= holds_requested;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest pending verdict
  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no chunk pending: tdata %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        seen_want = pending_verdicts.pop_front();
        if (m_axis_tdata_o[0 +: ENC_W] !== seen_want.enc) begin
          $error("encoding_guess: expected %0d, got %0d", seen_want.enc,
                 m_axis_tdata_o[0 +: ENC_W]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[ENC_W +: EOL_W] !== seen_want.eol) begin
          $error("eol_style: expected %0d, got %0d", seen_want.eol,
                 m_axis_tdata_o[ENC_W +: EOL_W]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("text_encoding_eol_detector_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    text_style_e style;
    eol_mix_e    mix;
    int          phase_start;
    foreach (line_counts[i]) line_counts[i] = 0;
    byte_count = 0;
    bom_code   = BOM_NONE;
    size_mod   = 2'd0;

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    write_config(BOM_NONE, 2'd0);

    // Directed: extremes, odd byte counts and the obvious verdicts
    foreach (DIRECTED_ROWS[r])
      send_word(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].nbytes, DIRECTED_ROWS[r].last,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].enc, DIRECTED_ROWS[r].eol);

    // Random: one configuration and idling pattern per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      write_config(PHASE_BOM[p], PHASE_MOD[p]);
      sender_idle_pct = PHASE_SEND_IDLE[p];
      recv_stall_pct  = PHASE_RECV_STALL[p];

      if (p == 4) begin
        // long chunk for the large-input rule, then back up the core with
        // single-word chunks while the receiver holds off
        send_chunk(text_style_e'($urandom_range(4)), $urandom_range(256, 280),
                   eol_mix_e'($urandom_range(3)));
        holds_requested++;
        repeat (24) send_chunk(text_style_e'($urandom_range(4)), 1,
                               eol_mix_e'($urandom_range(3)));
      end

      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        style = ($urandom_range(9) < 9) ? text_style_e'($urandom_range(4)) : STYLE_NOISE;
        mix   = eol_mix_e'($urandom_range(3));
        send_chunk(style, $urandom_range(1, 24), mix);
      end
    end

    quiesce();
    if (mismatch_count == 0)
      $display("text_encoding_eol_detector_core verification clean");
    else
      $display("text_encoding_eol_detector_core verification failed");
    $finish;
  end

endmodule
